// ----- sv/resp_request_stream_parser_assert.svh -----
// ----------------------------------------------------------------------------
// resp_request_stream_parser_assert
// Assertion macros shared by the request stream parser.
// ----------------------------------------------------------------------------
`ifndef RESP_REQUEST_STREAM_PARSER_ASSERT_SVH
`define RESP_REQUEST_STREAM_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/rrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrsp_pkg
// Types and constants of the request stream parser.
// ----------------------------------------------------------------------------
package rrsp_pkg;

   // Protocol characters.
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // Bits of the number flags.
   localparam int NF_DIGIT = 0;
   localparam int NF_NEG   = 1;
   localparam int NF_OVF   = 2;

   // Bits of the inline flags.
   localparam int IF_WORD = 0;
   localparam int IF_CR   = 1;

   // Configuration port.
   localparam int CSR_DATA_W        = 32;
   localparam int MAX_ARG_COUNT_W   = 24;
   localparam int MAX_BULK_LENGTH_W = 32;
   localparam logic [MAX_ARG_COUNT_W-1:0]   MAX_ARG_COUNT_RST   = 24'd1048576;
   localparam logic [MAX_BULK_LENGTH_W-1:0] MAX_BULK_LENGTH_RST = 32'd536870912;

   typedef enum logic {
      CSR_MAX_ARG_COUNT   = 1'b0,
      CSR_MAX_BULK_LENGTH = 1'b1
   } csr_index_type;

   // Result queue depth; a power of two, at least two.
   localparam int RES_DEPTH = 4;

   typedef enum logic [10:0] {
      M_IDLE    = 11'h001,
      M_CNT     = 11'h002,
      M_CNT_LF  = 11'h004,
      M_HDR     = 11'h008,
      M_LEN     = 11'h010,
      M_LEN_LF  = 11'h020,
      M_BODY    = 11'h040,
      M_BODY_CR = 11'h080,
      M_BODY_LF = 11'h100,
      M_INLINE  = 11'h200,
      M_ERR     = 11'h400
   } mode_type;

   typedef struct packed {
      logic byte_valid;
      logic arg_end;
      logic cmd_end;
      logic proto_error;
   } flag_type;

   // Number of results one request pushes into the result queue.
   typedef struct packed {
      logic [1:0] count;
   } push_type;

endpackage

// ----- sv/rrsp_parser.sv -----
// ----------------------------------------------------------------------------
// rrsp_parser
// Parser state, limit registers and the per-byte step that yields up to two
// packed results.
// ----------------------------------------------------------------------------
module rrsp_parser
   import rrsp_pkg::*;
#(
   parameter int COUNT_WIDTH  = 24,
   parameter int LENGTH_WIDTH = 32,
   parameter int RES_W        = 12 + 2 * COUNT_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  restart,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output push_type              push,
   output logic [RES_W-1:0]      res0,
   output logic [RES_W-1:0]      res1
);

   localparam int NUM_W = LENGTH_WIDTH + 1;
   localparam int CMP_W = ((NUM_W > 32) ? NUM_W : 32) + 1;
   localparam logic [CMP_W-1:0] COUNT_MASK =
      {{(CMP_W - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
   localparam logic [CMP_W-1:0] LENGTH_MASK =
      {{(CMP_W - LENGTH_WIDTH){1'b0}}, {LENGTH_WIDTH{1'b1}}};

   mode_type                  mode_ff, mode_in;
   logic [NUM_W-1:0]          acc_ff, acc_in;
   logic [2:0]                nflags_ff, nflags_in;
   logic [COUNT_WIDTH-1:0]    args_left_ff, args_left_in;
   logic [LENGTH_WIDTH-1:0]   body_left_ff, body_left_in;
   logic [COUNT_WIDTH-1:0]    arg_counter_ff, arg_counter_in;
   logic [1:0]                iflags_ff, iflags_in;
   logic [MAX_ARG_COUNT_W-1:0]   max_arg_count_ff;
   logic [MAX_BULK_LENGTH_W-1:0] max_bulk_length_ff;

   function automatic logic [RES_W-1:0] pack_res(input logic [7:0] ob, input flag_type f,
                                                 input logic [COUNT_WIDTH-1:0] idx,
                                                 input logic [COUNT_WIDTH-1:0] cnt);
      logic [7:0] b;
      b = f.byte_valid ? ob : 8'h00;
      return {b, f, idx, cnt};
   endfunction

   localparam flag_type FL_BYTE  = '{byte_valid: 1'b1, default: 1'b0};
   localparam flag_type FL_AEND  = '{arg_end: 1'b1, default: 1'b0};
   localparam flag_type FL_CEND  = '{cmd_end: 1'b1, default: 1'b0};
   localparam flag_type FL_ERR   = '{proto_error: 1'b1, default: 1'b0};
   localparam logic [COUNT_WIDTH-1:0] ZC = '0;

   logic [RES_W-1:0]     res_v [2];
   logic [1:0]           n;
   mode_type             cur;
   logic                 do_inline;
   logic                 is_digit;
   logic [NUM_W+3:0]     acc_x, acc_v;
   logic [CMP_W-1:0]     acc_c;
   logic                 base_ok, cnt_ok, len_ok;

   always_comb begin
      mode_in        = mode_ff;
      acc_in         = acc_ff;
      nflags_in      = nflags_ff;
      args_left_in   = args_left_ff;
      body_left_in   = body_left_ff;
      arg_counter_in = arg_counter_ff;
      iflags_in      = iflags_ff;
      if (restart) begin
         mode_in        = M_IDLE;
         acc_in         = '0;
         nflags_in      = '0;
         args_left_in   = '0;
         body_left_in   = '0;
         arg_counter_in = '0;
         iflags_in      = '0;
      end
      cur       = mode_in;
      res_v[0]  = '0;
      res_v[1]  = '0;
      n         = 2'd0;
      do_inline = 1'b0;

      // Digit accumulation: acc * 10 + digit; on overflow the old value is kept and the overflow flag is set.
      is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
      acc_x    = {4'b0000, acc_in};
      acc_v    = (acc_x << 3) + (acc_x << 1) + {{NUM_W{1'b0}}, data_byte[3:0]};

      acc_c   = {{(CMP_W - NUM_W){1'b0}}, acc_in};
      base_ok = nflags_in[NF_DIGIT] && !nflags_in[NF_OVF] &&
                !(nflags_in[NF_NEG] && (acc_in != '0));
      cnt_ok  = base_ok &&
                (acc_c <= {{(CMP_W - MAX_ARG_COUNT_W){1'b0}}, max_arg_count_ff}) &&
                (acc_c <= COUNT_MASK);
      len_ok  = base_ok &&
                (acc_c <= {{(CMP_W - MAX_BULK_LENGTH_W){1'b0}}, max_bulk_length_ff}) &&
                (acc_c <= LENGTH_MASK);

      unique case (cur)
         M_ERR: begin
         end
         M_CNT, M_LEN: begin
            if (data_byte == CH_CR) begin
               mode_in = (cur == M_CNT) ? M_CNT_LF : M_LEN_LF;
            end else if (data_byte == CH_MINUS && nflags_in == 3'b000) begin
               nflags_in[NF_NEG] = 1'b1;
            end else if (is_digit) begin
               if (acc_v[NUM_W+3:NUM_W] != 4'b0000) begin
                  nflags_in[NF_OVF] = 1'b1;
               end else begin
                  acc_in = acc_v[NUM_W-1:0];
               end
               nflags_in[NF_DIGIT] = 1'b1;
            end else begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end
         end
         M_CNT_LF: begin
            if (data_byte != CH_LF || !cnt_ok) begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end else if (acc_in == '0) begin
               // An empty multibulk command still reports its end.
               res_v[n[0]] = pack_res(8'h00, FL_CEND, ZC, ZC);
               n = n + 2'd1;
               mode_in        = M_IDLE;
               acc_in         = '0;
               nflags_in      = '0;
               args_left_in   = '0;
               body_left_in   = '0;
               arg_counter_in = '0;
               iflags_in      = '0;
            end else begin
               args_left_in   = acc_c[COUNT_WIDTH-1:0];
               arg_counter_in = '0;
               mode_in        = M_HDR;
            end
         end
         M_HDR: begin
            if (data_byte == CH_DOLLAR) begin
               mode_in   = M_LEN;
               acc_in    = '0;
               nflags_in = '0;
            end else begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end
         end
         M_LEN_LF: begin
            if (data_byte != CH_LF || !len_ok) begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end else begin
               body_left_in = acc_c[LENGTH_WIDTH-1:0];
               mode_in = (acc_c[LENGTH_WIDTH-1:0] != '0) ? M_BODY : M_BODY_CR;
            end
         end
         M_BODY: begin
            res_v[n[0]] = pack_res(data_byte, FL_BYTE, arg_counter_in, ZC);
            n = n + 2'd1;
            body_left_in = body_left_in - LENGTH_WIDTH'(1);
            if (body_left_in == '0) begin
               mode_in = M_BODY_CR;
            end
         end
         M_BODY_CR: begin
            if (data_byte == CH_CR) begin
               mode_in = M_BODY_LF;
            end else begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end
         end
         M_BODY_LF: begin
            if (data_byte != CH_LF) begin
               mode_in = M_ERR;
               res_v[n[0]] = pack_res(8'h00, FL_ERR, ZC, ZC);
               n = n + 2'd1;
            end else begin
               res_v[n[0]] = pack_res(8'h00, FL_AEND, arg_counter_in, ZC);
               n = n + 2'd1;
               arg_counter_in = arg_counter_in + COUNT_WIDTH'(1);
               args_left_in   = args_left_in - COUNT_WIDTH'(1);
               if (args_left_in == '0) begin
                  res_v[n[0]] = pack_res(8'h00, FL_CEND, ZC, arg_counter_in);
                  n = n + 2'd1;
                  mode_in        = M_IDLE;
                  acc_in         = '0;
                  nflags_in      = '0;
                  args_left_in   = '0;
                  body_left_in   = '0;
                  arg_counter_in = '0;
                  iflags_in      = '0;
               end else begin
                  mode_in = M_HDR;
               end
            end
         end
         M_INLINE: begin
            do_inline = 1'b1;
         end
         M_IDLE: begin
            if (data_byte == CH_STAR) begin
               mode_in   = M_CNT;
               acc_in    = '0;
               nflags_in = '0;
            end else begin
               mode_in   = M_INLINE;
               do_inline = 1'b1;
            end
         end
         default: begin
            mode_in = M_ERR;
         end
      endcase

      // Inline form: words split on space or tab, ended by LF.
      if (do_inline) begin
         if (data_byte == CH_LF) begin
            if (iflags_in[IF_WORD]) begin
               res_v[n[0]] = pack_res(8'h00, FL_AEND, arg_counter_in, ZC);
               n = n + 2'd1;
               if (arg_counter_in != '1) begin
                  arg_counter_in = arg_counter_in + COUNT_WIDTH'(1);
               end
            end
            res_v[n[0]] = pack_res(8'h00, FL_CEND, ZC, arg_counter_in);
            n = n + 2'd1;
            mode_in        = M_IDLE;
            acc_in         = '0;
            nflags_in      = '0;
            args_left_in   = '0;
            body_left_in   = '0;
            arg_counter_in = '0;
            iflags_in      = '0;
         end else begin
            // A held CR that is not followed by LF belongs to the word.
            if (iflags_in[IF_CR]) begin
               iflags_in[IF_CR]   = 1'b0;
               iflags_in[IF_WORD] = 1'b1;
               res_v[n[0]] = pack_res(CH_CR, FL_BYTE, arg_counter_in, ZC);
               n = n + 2'd1;
            end
            if (data_byte == CH_CR) begin
               iflags_in[IF_CR] = 1'b1;
            end else if (data_byte == CH_SPACE || data_byte == CH_TAB) begin
               if (iflags_in[IF_WORD]) begin
                  res_v[n[0]] = pack_res(8'h00, FL_AEND, arg_counter_in, ZC);
                  n = n + 2'd1;
                  if (arg_counter_in != '1) begin
                     arg_counter_in = arg_counter_in + COUNT_WIDTH'(1);
                  end
                  iflags_in[IF_WORD] = 1'b0;
               end
            end else begin
               iflags_in[IF_WORD] = 1'b1;
               res_v[n[0]] = pack_res(data_byte, FL_BYTE, arg_counter_in, ZC);
               n = n + 2'd1;
            end
         end
      end
   end

   assign push.count = accept ? n : 2'd0;
   assign res0       = res_v[0];
   assign res1       = res_v[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_IDLE;
         acc_ff         <= '0;
         nflags_ff      <= '0;
         args_left_ff   <= '0;
         body_left_ff   <= '0;
         arg_counter_ff <= '0;
         iflags_ff      <= '0;
      end else if (accept) begin
         mode_ff        <= mode_in;
         acc_ff         <= acc_in;
         nflags_ff      <= nflags_in;
         args_left_ff   <= args_left_in;
         body_left_ff   <= body_left_in;
         arg_counter_ff <= arg_counter_in;
         iflags_ff      <= iflags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_arg_count_ff   <= MAX_ARG_COUNT_RST;
         max_bulk_length_ff <= MAX_BULK_LENGTH_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_ARG_COUNT:   max_arg_count_ff   <= csr_wdata[MAX_ARG_COUNT_W-1:0];
            CSR_MAX_BULK_LENGTH: max_bulk_length_ff <= csr_wdata[MAX_BULK_LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

// ----- sv/rrsp_fifo.sv -----
// ----------------------------------------------------------------------------
// rrsp_fifo
// Result queue that takes up to two entries per cycle and hands out one.
// ----------------------------------------------------------------------------
module rrsp_fifo
   import rrsp_pkg::*;
#(
   parameter int WIDTH = 60
) (
   input  logic             clock,
   input  logic             reset,
   input  push_type         push,
   input  logic [WIDTH-1:0] in0,
   input  logic [WIDTH-1:0] in1,
   output logic             in_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = $clog2(RES_DEPTH);
   localparam int CNT_W = $clog2(RES_DEPTH + 1);

   logic [WIDTH-1:0] mem [RES_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   // Room for the two results one request may push.
   assign in_ready  = (count_ff <= CNT_W'(RES_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign count_in  = count_ff + CNT_W'(push.count) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= in0;
      end
      if (push.count == 2'd2) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= in1;
      end
   end

endmodule

// ----- sv/resp_request_stream_parser.sv -----
// ----------------------------------------------------------------------------
// resp_request_stream_parser
// Streaming parser for multibulk and inline client requests.
//
//   Channel  Ports  Moves
//   -------  -----  -------------------------------------------
//   input    req_   one received byte per request, with restart
//   output   rsp_   one argument byte or marker per result
//   config   csr_   limit register writes, no read-back
//
// One request is taken per cycle; its results are in the queue on the next
// cycle. A byte yields at most two results, so a request is held off only
// while the four-entry result queue has fewer than two free slots.
// Reset is synchronous and restores the parser to idle and the limits to their
// defaults. A stalled consumer stops the input once three or more results wait.
// ----------------------------------------------------------------------------
`include "resp_request_stream_parser_assert.svh"

module resp_request_stream_parser
   import rrsp_pkg::*;
#(
   parameter int COUNT_WIDTH  = 24,
   parameter int LENGTH_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_restart,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_byte_valid,
   output logic [COUNT_WIDTH-1:0] rsp_arg_index,
   output logic                   rsp_arg_end,
   output logic                   rsp_cmd_end,
   output logic [COUNT_WIDTH-1:0] rsp_arg_count,
   output logic                   rsp_proto_error,
   input  logic                   csr_wr_en,
   input  csr_index_type          csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int RES_W = 12 + 2 * COUNT_WIDTH;

   logic             accept;
   push_type         push;
   logic [RES_W-1:0] res0, res1, head;
   flag_type         head_flags;

   assign accept = req_valid && req_ready;

   rrsp_parser #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .LENGTH_WIDTH(LENGTH_WIDTH),
      .RES_W       (RES_W)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .data_byte(req_data_byte),
      .restart  (req_restart),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .push     (push),
      .res0     (res0),
      .res1     (res1)
   );

   rrsp_fifo #(
      .WIDTH(RES_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .in0      (res0),
      .in1      (res1),
      .in_ready (req_ready),
      .out_valid(rsp_valid),
      .out_ready(rsp_ready),
      .out_data (head)
   );

   assign rsp_out_byte    = head[RES_W-1 -: 8];
   assign head_flags      = head[2*COUNT_WIDTH +: 4];
   assign rsp_byte_valid  = head_flags.byte_valid;
   assign rsp_arg_end     = head_flags.arg_end;
   assign rsp_cmd_end     = head_flags.cmd_end;
   assign rsp_proto_error = head_flags.proto_error;
   assign rsp_arg_index   = head[COUNT_WIDTH +: COUNT_WIDTH];
   assign rsp_arg_count   = head[0 +: COUNT_WIDTH];

   `RRSP_ASSERT_SAME(a_push_on_accept, clock, reset, push.count != 2'd0, accept,
                     "result pushed without an accepted request")
   `RRSP_ASSERT_NEXT(a_push_shows, clock, reset, push.count != 2'd0, rsp_valid,
                     "pushed result not visible")
   `RRSP_ASSERT_SAME(a_cmd_end_clean, clock, reset, rsp_valid && rsp_cmd_end,
                     !rsp_byte_valid && !rsp_proto_error && !rsp_arg_end,
                     "command end mixed with other markers")

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming multibulk/inline request parser.
// Byte requests come from a queue that the stimulus process fills with
// directed sequences and random commands, both well-formed and broken. Every
// accepted request is run through a bit-accurate predictor of the parser, and
// each result is checked field by field against the oldest prediction. The
// run goes through several limit settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   import rrsp_pkg::*;

   localparam int            TAIL_CYCLES    = 8;
   localparam int            WATCHDOG_LIMIT = 2000;
   localparam logic [63:0]   COUNT_MASK     = (64'd1 << 24) - 64'd1;
   localparam logic [63:0]   LENGTH_MASK    = (64'd1 << 32) - 64'd1;
   localparam logic [63:0]   ACC_CAP        = (64'd1 << 33) - 64'd1;

   typedef struct {
      logic [7:0]  out_byte;
      logic        byte_valid;
      logic [23:0] arg_index;
      logic        arg_end;
      logic        cmd_end;
      logic [23:0] arg_count;
      logic        proto_error;
   } parse_result_type;

   typedef struct {
      logic [7:0] data;
      logic       restart;
      logic       hold;
   } feed_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = 8'd0;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_byte_valid;
   logic [23:0]           rsp_arg_index;
   logic                  rsp_arg_end;
   logic                  rsp_cmd_end;
   logic [23:0]           rsp_arg_count;
   logic                  rsp_proto_error;
   logic                  csr_wr_en = 1'b0;
   csr_index_type         csr_index = CSR_MAX_ARG_COUNT;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   feed_item_type    byte_feed[$];
   parse_result_type parsed_stream[$];
   logic [7:0]       cmd_bytes[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int results_seen   = 0;
   int idle_cycles    = 0;

   // Predictor copy of the limits and the parser state.
   logic [23:0] cfg_max_args = MAX_ARG_COUNT_RST;
   logic [31:0] cfg_max_len  = MAX_BULK_LENGTH_RST;
   mode_type    pmode        = M_IDLE;
   logic [32:0] num_acc      = '0;
   logic [2:0]  num_flags    = '0;
   logic [23:0] args_left    = '0;
   logic [31:0] body_left    = '0;
   logic [23:0] arg_ctr      = '0;
   logic [1:0]  inl_flags    = '0;

   resp_request_stream_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_arg_index   (rsp_arg_index),
      .rsp_arg_end     (rsp_arg_end),
      .rsp_cmd_end     (rsp_cmd_end),
      .rsp_arg_count   (rsp_arg_count),
      .rsp_proto_error (rsp_proto_error),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------ predictor

   function automatic void push_result(input logic [7:0] b, input logic v,
                                       input logic [23:0] idx, input logic ae,
                                       input logic ce, input logic [23:0] cnt,
                                       input logic er);
      parse_result_type r;
      r.out_byte    = v ? b : 8'd0;
      r.byte_valid  = v;
      r.arg_index   = idx;
      r.arg_end     = ae;
      r.cmd_end     = ce;
      r.arg_count   = cnt;
      r.proto_error = er;
      parsed_stream.insert(parsed_stream.size(), r);
   endfunction

   function automatic void clear_parse();
      pmode     = M_IDLE;
      num_acc   = '0;
      num_flags = '0;
      args_left = '0;
      body_left = '0;
      arg_ctr   = '0;
      inl_flags = '0;
   endfunction

   function automatic void flag_error();
      pmode = M_ERR;
      push_result(8'd0, 1'b0, 24'd0, 1'b0, 1'b0, 24'd0, 1'b1);
   endfunction

   function automatic void start_number(input mode_type m);
      pmode     = m;
      num_acc   = '0;
      num_flags = '0;
   endfunction

   // Returns 1 when the byte belongs to a digit line (sign or digit).
   function automatic bit take_digit(input logic [7:0] b);
      logic [63:0] v;
      if (b == CH_MINUS && num_flags == 3'b000) begin
         num_flags[NF_NEG] = 1'b1;
         return 1'b1;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
         v = 64'(num_acc) * 64'd10 + 64'(b - CH_ZERO);
         if (v > ACC_CAP) begin
            num_flags[NF_OVF] = 1'b1;
         end else begin
            num_acc = v[32:0];
         end
         num_flags[NF_DIGIT] = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit number_fits(input logic [63:0] limit, input logic [63:0] wmask);
      if (!num_flags[NF_DIGIT] || num_flags[NF_OVF]) return 1'b0;
      if (num_flags[NF_NEG] && num_acc != 0) return 1'b0;
      return (64'(num_acc) <= limit) && (64'(num_acc) <= wmask);
   endfunction

   function automatic void count_word();
      if (arg_ctr != COUNT_MASK[23:0]) arg_ctr = arg_ctr + 24'd1;
   endfunction

   function automatic void inline_step(input logic [7:0] b);
      if (b == CH_LF) begin
         if (inl_flags[IF_WORD]) begin
            push_result(8'd0, 1'b0, arg_ctr, 1'b1, 1'b0, 24'd0, 1'b0);
            count_word();
         end
         push_result(8'd0, 1'b0, 24'd0, 1'b0, 1'b1, arg_ctr, 1'b0);
         clear_parse();
         return;
      end
      // A held CR that is not followed by LF turns into a word byte now.
      if (inl_flags[IF_CR]) begin
         inl_flags[IF_CR]   = 1'b0;
         inl_flags[IF_WORD] = 1'b1;
         push_result(CH_CR, 1'b1, arg_ctr, 1'b0, 1'b0, 24'd0, 1'b0);
      end
      if (b == CH_CR) begin
         inl_flags[IF_CR] = 1'b1;
      end else if (b == CH_SPACE || b == CH_TAB) begin
         if (inl_flags[IF_WORD]) begin
            push_result(8'd0, 1'b0, arg_ctr, 1'b1, 1'b0, 24'd0, 1'b0);
            count_word();
            inl_flags[IF_WORD] = 1'b0;
         end
      end else begin
         inl_flags[IF_WORD] = 1'b1;
         push_result(b, 1'b1, arg_ctr, 1'b0, 1'b0, 24'd0, 1'b0);
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic restart);
      if (restart) clear_parse();
      case (pmode)
         M_ERR: begin
         end
         M_CNT, M_LEN: begin
            if (b == CH_CR) begin
               if (pmode == M_CNT) pmode = M_CNT_LF;
               else pmode = M_LEN_LF;
            end else if (!take_digit(b)) begin
               flag_error();
            end
         end
         M_CNT_LF: begin
            if (b != CH_LF || !number_fits(64'(cfg_max_args), COUNT_MASK)) begin
               flag_error();
            end else if (num_acc == 0) begin
               push_result(8'd0, 1'b0, 24'd0, 1'b0, 1'b1, 24'd0, 1'b0);
               clear_parse();
            end else begin
               args_left = num_acc[23:0];
               arg_ctr   = '0;
               pmode     = M_HDR;
            end
         end
         M_HDR: begin
            if (b == CH_DOLLAR) start_number(M_LEN);
            else flag_error();
         end
         M_LEN_LF: begin
            if (b != CH_LF || !number_fits(64'(cfg_max_len), LENGTH_MASK)) begin
               flag_error();
            end else begin
               body_left = num_acc[31:0];
               if (body_left != 0) pmode = M_BODY;
               else pmode = M_BODY_CR;
            end
         end
         M_BODY: begin
            push_result(b, 1'b1, arg_ctr, 1'b0, 1'b0, 24'd0, 1'b0);
            body_left = body_left - 32'd1;
            if (body_left == 0) pmode = M_BODY_CR;
         end
         M_BODY_CR: begin
            if (b == CH_CR) pmode = M_BODY_LF;
            else flag_error();
         end
         M_BODY_LF: begin
            if (b != CH_LF) begin
               flag_error();
            end else begin
               push_result(8'd0, 1'b0, arg_ctr, 1'b1, 1'b0, 24'd0, 1'b0);
               arg_ctr   = arg_ctr + 24'd1;
               args_left = args_left - 24'd1;
               if (args_left == 0) begin
                  push_result(8'd0, 1'b0, 24'd0, 1'b0, 1'b1, arg_ctr, 1'b0);
                  clear_parse();
               end else begin
                  pmode = M_HDR;
               end
            end
         end
         M_INLINE: begin
            inline_step(b);
         end
         default: begin
            if (b == CH_STAR) begin
               start_number(M_CNT);
            end else begin
               clear_parse();
               pmode = M_INLINE;
               inline_step(b);
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------ stimulus

   function automatic void put(input logic [7:0] b);
      cmd_bytes.insert(cmd_bytes.size(), b);
   endfunction

   function automatic void put_crlf();
      put(CH_CR);
      put(CH_LF);
   endfunction

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endfunction

   // Decimal digits of v, now and then with a leading zero.
   function automatic void put_decimal(input logic [63:0] v);
      logic [7:0]  digs[$];
      logic [63:0] x;
      x = v;
      do begin
         digs.push_front(CH_ZERO + 8'(x % 64'd10));
         x = x / 64'd10;
      end while (x != 0);
      if ($urandom_range(7) == 0) put(CH_ZERO);
      foreach (digs[i]) put(digs[i]);
   endfunction

   function automatic void put_sep();
      repeat ($urandom_range(1, 2)) put($urandom_range(1) ? CH_SPACE : CH_TAB);
   endfunction

   function automatic logic [7:0] word_byte();
      logic [7:0] b;
      if ($urandom_range(9) == 0) return CH_CR;
      do b = 8'($urandom); while (b == CH_LF || b == CH_CR || b == CH_SPACE || b == CH_TAB);
      return b;
   endfunction

   // Returns 1 when the current limits may reject the command.
   function automatic bit build_multibulk(input int max_n, input int max_len);
      int n;
      int len;
      bit risky;
      n     = $urandom_range(max_n);
      risky = (n > cfg_max_args);
      put(CH_STAR);
      put_decimal(64'(n));
      put_crlf();
      for (int i = 0; i < n; i++) begin
         len = $urandom_range(max_len);
         if (len > cfg_max_len) risky = 1'b1;
         put(CH_DOLLAR);
         put_decimal(64'(len));
         put_crlf();
         repeat (len) put(8'($urandom));
         put_crlf();
      end
      return risky;
   endfunction

   function automatic void build_inline();
      int words;
      words = $urandom_range(4);
      if ($urandom_range(3) == 0) put_sep();
      for (int i = 0; i < words; i++) begin
         if (i != 0) put_sep();
         repeat ($urandom_range(1, 5)) put(word_byte());
      end
      if ($urandom_range(3) == 0) put_sep();
      case ($urandom_range(2))
         0: put(CH_LF);
         1: put_crlf();
         default: begin
            put(CH_CR);
            put_crlf();
         end
      endcase
      // A leading star would select the multibulk form instead.
      if (cmd_bytes[0] == CH_STAR) cmd_bytes[0] = "x";
   endfunction

   function automatic void build_digit_case();
      logic [7:0] b;
      case ($urandom_range(12))
         0: begin
            put_text("*-");
            put_decimal(64'($urandom_range(1, 99)));
            put_crlf();
         end
         1: begin
            put(CH_STAR);
            put_crlf();
         end
         2: begin
            put_text("*--1");
            put_crlf();
         end
         3: begin
            put_text("*1-");
            put_crlf();
         end
         4: begin
            put_text("*12");
            put(CH_LF);
         end
         5: begin
            put_text("*3");
            put(CH_CR);
            do b = 8'($urandom); while (b == CH_LF);
            put(b);
         end
         6: begin
            // Around the top of the accumulator, and well past it.
            put(CH_STAR);
            if ($urandom_range(1)) put_decimal(ACC_CAP + 64'($urandom_range(1)));
            else put_decimal(64'd99999999999 + 64'($urandom_range(999)));
            put_crlf();
         end
         7: begin
            put(CH_STAR);
            put_decimal(64'(cfg_max_args) + 64'd1);
            put_crlf();
         end
         8: begin
            put_text("*1");
            put_crlf();
            do b = 8'($urandom); while (b == CH_DOLLAR);
            put(b);
         end
         9: begin
            put_text("*1");
            put_crlf();
            put(CH_DOLLAR);
            put_decimal(64'(cfg_max_len) + 64'd1);
            put_crlf();
         end
         10: begin
            put_text("*1");
            put_crlf();
            put_text("$-0");
            put_crlf();
            put_crlf();
         end
         11: begin
            put_text("*1");
            put_crlf();
            put_text("$1");
            put_crlf();
            put(8'($urandom));
            if ($urandom_range(1)) begin
               do b = 8'($urandom); while (b == CH_CR);
            end else begin
               put(CH_CR);
               do b = 8'($urandom); while (b == CH_LF);
            end
            put(b);
         end
         default: begin
            put_text("*1");
            put_crlf();
            put_text("$2");
            put(CH_LF);
            put_text("ab");
            put_crlf();
         end
      endcase
   endfunction

   function automatic void build_noise();
      repeat ($urandom_range(1, 6)) put(8'($urandom));
   endfunction

   // Replace one byte with a random one, or cut the command short.
   function automatic void corrupt();
      int at;
      at = $urandom_range(cmd_bytes.size() - 1);
      if ($urandom_range(1)) cmd_bytes[at] = 8'($urandom);
      else while (cmd_bytes.size() > at + 1) void'(cmd_bytes.pop_back());
   endfunction

   // Moves the built command into the request queue; returns its length.
   function automatic int queue_command(input bit first_restart, input bit noisy,
                                        input bit hold);
      feed_item_type it;
      int n;
      n = cmd_bytes.size();
      foreach (cmd_bytes[i]) begin
         it.data    = cmd_bytes[i];
         it.restart = (i == 0 && first_restart) || (noisy && $urandom_range(3) == 0);
         it.hold    = (i == 0) && hold;
         byte_feed.insert(byte_feed.size(), it);
      end
      cmd_bytes.delete();
      return n;
   endfunction

   function automatic void queue_directed();
      put_text("*-0");
      put_crlf();
      void'(queue_command(1'b0, 1'b0, 1'b0));
      put_text("*1");
      put_crlf();
      put_text("$2");
      put_crlf();
      put(8'h00);
      put(8'hFF);
      put_crlf();
      void'(queue_command(1'b0, 1'b0, 1'b0));
      put(CH_LF);
      void'(queue_command(1'b0, 1'b0, 1'b0));
      put("a");
      put(CH_CR);
      put(CH_TAB);
      put("b");
      put_crlf();
      void'(queue_command(1'b0, 1'b0, 1'b0));
      // Error, then a byte that the sticky error swallows.
      put_text("*xy");
      void'(queue_command(1'b1, 1'b0, 1'b0));
   endfunction

   function automatic void fill_random(input int n_items);
      int added;
      int kind;
      bit broke;
      bit first_cmd;
      bit risky;
      added     = 0;
      broke     = 1'b1;
      first_cmd = 1'b1;
      while (added < n_items) begin
         kind  = $urandom_range(99);
         risky = 1'b0;
         if (kind < 45) begin
            risky = build_multibulk(4, ($urandom_range(9) == 0) ? 24 : 6);
         end else if (kind < 70) begin
            build_inline();
         end else if (kind < 80) begin
            if ($urandom_range(1)) void'(build_multibulk(3, 4));
            else build_inline();
            corrupt();
         end else if (kind < 94) begin
            build_digit_case();
         end else begin
            build_noise();
         end
         added += queue_command(broke || $urandom_range(3) == 0, kind >= 94,
                                first_cmd || $urandom_range(49) == 0);
         broke     = risky || kind >= 70;
         first_cmd = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------ checking

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s is %0h, expected %0h",
                                   results_seen, name, got, want));
   endtask

   // ------------------------------------------------------------------ driver

   always @(posedge clock) begin
      feed_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) parse_byte(req_data_byte, req_restart);
         if (!req_valid || req_ready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(byte_feed[0].hold && parsed_stream.size() != 0)) begin
               next_item = byte_feed.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= next_item.data;
               req_restart   <= next_item.restart;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------ monitor

   always @(posedge clock) begin
      parse_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parsed_stream.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want = parsed_stream.pop_front();
               check_field("out_byte", 32'(rsp_out_byte), 32'(want.out_byte));
               check_field("byte_valid", 32'(rsp_byte_valid), 32'(want.byte_valid));
               check_field("arg_index", 32'(rsp_arg_index), 32'(want.arg_index));
               check_field("arg_end", 32'(rsp_arg_end), 32'(want.arg_end));
               check_field("cmd_end", 32'(rsp_cmd_end), 32'(want.cmd_end));
               check_field("arg_count", 32'(rsp_arg_count), 32'(want.arg_count));
               check_field("proto_error", 32'(rsp_proto_error), 32'(want.proto_error));
            end
            results_seen++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------ watchdog

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------ sequence

   task automatic write_csr(input csr_index_type idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_MAX_ARG_COUNT) cfg_max_args = data[23:0];
      else cfg_max_len = data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every request is taken and every result checked, then waits
   // out a tail in case a request with no result is still inside.
   task automatic settle();
      while (byte_feed.size() != 0 || req_valid || parsed_stream.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [23:0] arg_lim, input logic [31:0] len_lim,
                            input int idle_pct, input int stall_pct, input int n_items);
      write_csr(CSR_MAX_ARG_COUNT, 32'(arg_lim));
      write_csr(CSR_MAX_BULK_LENGTH, len_lim);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      fill_random(n_items);
      settle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      queue_directed();
      fill_random(300);
      settle();
      run_phase(24'hFFFFFF, 32'hFFFFFFFF, 88, 0, 350);
      run_phase(24'd0, 32'd0, 0, 88, 300);
      run_phase(24'd3, 32'd4, 6, 6, 400);
      run_phase(24'd1000, 32'd7, 0, 0, 450);
      if (parsed_stream.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   parsed_stream.size()));
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
